@@ hdl/chol_pkg.sv @@
package chol_pkg;

	localparam int QFRAC = 30;
	localparam int STORE_DEPTH = 64;
	localparam int STORE_AW = 6;
	localparam int MAX_SIZE = 8;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ENTRY,
		ST_RD_WAIT,
		ST_DOT,
		ST_DRAIN,
		ST_FIN,
		ST_SQRT,
		ST_DIV,
		ST_WRITE,
		ST_EMIT_RD,
		ST_EMIT
	} chol_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_wr;
		logic       entry_init;
		logic       dot_step;
		logic       sat_fin;
		logic       sqrt_start;
		logic       div_start;
		logic       write_l;
		logic       clear_err;
		logic       emit_load;
		logic [2:0] i;
		logic [2:0] j;
		logic [2:0] k;
	} chol_cmd_t;

	// Status returned by the datapath.
	typedef struct packed {
		logic unit_done;
		logic out_busy;
	} chol_stat_t;

endpackage

@@ hdl/chol_datapath.sv @@
module chol_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  chol_pkg::chol_cmd_t  cmd,
	output chol_pkg::chol_stat_t stat,
	input  logic [31:0]       in_element,
	input  logic [5:0]        load_addr,
	input  logic [5:0]        rd_addr,
	input  logic              out_last,
	output logic              m_valid,
	input  logic              m_ready,
	output logic [39:0]       m_data,
	output logic              m_last
);
	import chol_pkg::*;

	logic [31:0] store_q [STORE_DEPTH];
	logic [31:0] rd_q;
	logic signed [31:0] lf_q [64];
	logic signed [70:0] s_q;
	logic signed [31:0] s_sat_q;
	logic err_q;
	logic signed [31:0] a_q, b_q;
	logic signed [63:0] prod_s2;
	logic dot_v_s1;
	logic prod_v_s2;
	// Iterative units
	logic [63:0] rad_q;
	logic [31:0] root_q;
	logic [33:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        is_div_q;
	logic [62:0] num_q;
	logic [31:0] den_q;
	logic [62:0] quo_q;
	logic [31:0] drem_q;
	logic        neg_q;
	logic signed [31:0] res_q;
	logic        done_q;
	logic [33:0] trial;
	logic [33:0] rem_sh;
	logic [32:0] drem_sh;
	logic [63:0] num_mag;

	// Element store, written on load and read with registered data.
	always_ff @(posedge clk) begin
		if (cmd.load_wr) store_q[load_addr] <= in_element;
		rd_q <= store_q[rd_addr];
	end

	// Two registered reads of the factor store feed the multiplier; port B also
	// holds the pivot L[j][j] while the divider starts, port A the emitted entry.
	always_ff @(posedge clk) begin
		prod_s2 <= a_q * b_q;
		a_q <= lf_q[{cmd.i, cmd.k}];
		b_q <= lf_q[{cmd.j, cmd.k}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_v_s1 <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			dot_v_s1 <= cmd.dot_step;
			prod_v_s2 <= dot_v_s1;
		end
	end

	// Accumulator with rounded product subtraction and saturation.
	always_ff @(posedge clk) begin
		if (cmd.entry_init) s_q <= 71'(signed'(rd_q));
		else if (prod_v_s2)
			s_q <= s_q - 71'((prod_s2 + 64'sd536870912) >>> QFRAC);
		if (cmd.sat_fin) begin
			if (s_q > 71'sd2147483647) s_sat_q <= 32'h7fffffff;
			else if (s_q < -71'sd2147483648) s_sat_q <= 32'h80000000;
			else s_sat_q <= s_q[31:0];
		end
	end

	assign rem_sh = {rem_q[31:0], rad_q[63:62]};
	assign trial = {root_q, 2'b01};
	assign drem_sh = {drem_q, num_q[62]};
	assign num_mag = s_sat_q[31] ? 64'(-{{32{s_sat_q[31]}}, s_sat_q}) : 64'(s_sat_q);

	// Square root, two bits a cycle, and restoring divide, one bit a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.sqrt_start) begin
				busy_q <= 1'b1;
				is_div_q <= 1'b0;
				cnt_q <= 6'd32;
				rad_q <= {2'b00, s_sat_q, 30'd0};
				root_q <= '0;
				rem_q <= '0;
				if (s_sat_q[31] || s_sat_q == 0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					res_q <= '0;
				end
			end else if (cmd.div_start) begin
				busy_q <= 1'b1;
				is_div_q <= 1'b1;
				cnt_q <= 6'd63;
				num_q <= 63'(num_mag << QFRAC);
				den_q <= b_q;
				neg_q <= s_sat_q[31];
				drem_q <= '0;
				quo_q <= '0;
				if (b_q[31] || b_q == 0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					res_q <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (!is_div_q) begin
					rad_q <= rad_q << 2;
					if (rem_sh >= trial) begin
						rem_q <= rem_sh - trial;
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						root_q <= {root_q[30:0], 1'b0};
					end
					if (cnt_q == 6'd1) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
						res_q <= (rem_sh >= trial) ? {root_q[30:0], 1'b1}
						                           : {root_q[30:0], 1'b0};
					end
				end else begin
					num_q <= num_q << 1;
					if (drem_sh >= {1'b0, den_q}) begin
						drem_q <= 32'(drem_sh - {1'b0, den_q});
						quo_q <= {quo_q[61:0], 1'b1};
					end else begin
						drem_q <= drem_sh[31:0];
						quo_q <= {quo_q[61:0], 1'b0};
					end
					if (cnt_q == 6'd1) busy_q <= 1'b0;
				end
			end else if (is_div_q && cnt_q == 6'd0 && !done_q && den_q != 0) begin
				done_q <= 1'b1;
				den_q <= '0;
				if (!neg_q) res_q <= (quo_q > 63'h7fffffff) ? 32'h7fffffff : quo_q[31:0];
				else res_q <= (quo_q > 63'h80000000) ? 32'h80000000 : 32'(-quo_q);
			end
		end
	end

	assign stat.unit_done = done_q;

	// Factor store and pivot flag.
	always_ff @(posedge clk) begin
		if (cmd.write_l) lf_q[{cmd.i, cmd.j}] <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) err_q <= 1'b0;
		else if (cmd.clear_err) err_q <= 1'b0;
		else if (cmd.sqrt_start && (s_sat_q[31] || s_sat_q == 0)) err_q <= 1'b1;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid <= 1'b0;
		else if (cmd.emit_load) m_valid <= 1'b1;
		else if (m_ready) m_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			m_data <= {1'b0, err_q, cmd.j, cmd.i,
			           (cmd.j <= cmd.i) ? a_q : 32'sd0};
			m_last <= out_last;
		end
	end

	assign stat.out_busy = m_valid && !m_ready;

endmodule

@@ hdl/chol_ctrl.sv @@
module chol_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  logic              s_last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_data,
	input  chol_pkg::chol_stat_t stat,
	output chol_pkg::chol_cmd_t  cmd,
	output logic [5:0]        load_addr,
	output logic [5:0]        rd_addr,
	output logic              out_last
);
	import chol_pkg::*;

	chol_state_t state_q, state_d;
	logic [3:0] size_q;
	logic [3:0] n;
	logic [6:0] load_cnt_q;
	logic [2:0] i_q, j_q, k_q;
	logic [6:0] rowbase;
	logic s_acc;

	assign n = (size_q == 0) ? 4'd1 : ((size_q > 4'(MAX_SIZE)) ? 4'(MAX_SIZE) : size_q);
	assign cfg_ready = 1'b1;
	assign s_ready = (state_q == ST_LOAD);
	assign s_acc = s_valid && s_ready;
	assign load_addr = load_cnt_q[5:0];
	assign rowbase = 7'(i_q) * 7'(n);
	assign rd_addr = 6'(rowbase + 7'(j_q));
	assign out_last = (4'(i_q) == n - 4'd1) && (4'(j_q) == n - 4'd1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:    if (s_acc && s_last) state_d = ST_ENTRY;
			ST_ENTRY:   state_d = ST_RD_WAIT;
			ST_RD_WAIT: state_d = ST_DOT;
			ST_DOT:     if (k_q == j_q) state_d = ST_DRAIN;
			ST_DRAIN:   state_d = ST_FIN;
			ST_FIN:     state_d = (i_q == j_q) ? ST_SQRT : ST_DIV;
			ST_SQRT:    state_d = ST_WRITE;
			ST_DIV:     state_d = ST_WRITE;
			ST_WRITE:   if (stat.unit_done)
				state_d = (i_q == j_q && 4'(i_q) == n - 4'd1) ? ST_EMIT_RD : ST_ENTRY;
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT:    if (!stat.out_busy) state_d = out_last ? ST_LOAD : ST_EMIT_RD;
			default:    state_d = ST_LOAD;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd = '0;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.k = k_q;
		unique case (state_q)
			ST_LOAD:    begin
				cmd.load_wr = s_acc && !load_cnt_q[6];
				cmd.clear_err = s_acc && s_last;
			end
			ST_RD_WAIT: cmd.entry_init = 1'b1;
			ST_DOT:     cmd.dot_step = (k_q != j_q);
			ST_FIN:     cmd.sat_fin = 1'b1;
			ST_SQRT:    cmd.sqrt_start = 1'b1;
			ST_DIV:     cmd.div_start = 1'b1;
			ST_WRITE:   cmd.write_l = stat.unit_done;
			// The factor store read port follows the emitted entry.
			ST_EMIT_RD: cmd.k = j_q;
			ST_EMIT:    begin
				cmd.k = j_q;
				cmd.emit_load = !stat.out_busy;
			end
			default:    ;
		endcase
	end

	// State, counters and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			size_q <= 4'd8;
			load_cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) size_q <= cfg_data;
			if (state_q == ST_LOAD && s_acc) begin
				if (!load_cnt_q[6]) load_cnt_q <= load_cnt_q + 7'd1;
				i_q <= '0;
				j_q <= '0;
			end
			if (state_q == ST_ENTRY) k_q <= '0;
			if (state_q == ST_DOT && k_q != j_q) k_q <= k_q + 3'd1;
			if (state_q == ST_WRITE && stat.unit_done) begin
				if (i_q == j_q) begin
					if (4'(i_q) == n - 4'd1) i_q <= '0;
					else i_q <= i_q + 3'd1;
					j_q <= '0;
				end else j_q <= j_q + 3'd1;
			end
			if (state_q == ST_EMIT && !stat.out_busy) begin
				if (out_last) begin
					i_q <= '0;
					j_q <= '0;
					load_cnt_q <= '0;
				end else if (4'(j_q) == n - 4'd1) begin
					j_q <= '0;
					i_q <= i_q + 3'd1;
				end else j_q <= j_q + 3'd1;
			end
		end
	end

`ifndef SYNTH
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_wr |-> state_q == ST_LOAD)
		else $error("store write outside load");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DOT |-> k_q <= j_q)
		else $error("dot index overrun");
	a_j_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> j_q <= i_q)
		else $error("column above diagonal");
`endif

endmodule

@@ hdl/cholesky_decomposition_top.sv @@
// Cholesky factorization of a symmetric positive-definite matrix, Q2.30.
// Input stream s_*: one matrix element per transaction in row-major order,
// s_tlast on the final element starts the factorization.
// Output stream m_*: matrix_size squared factor entries in row-major order,
// zeros above the diagonal, m_tlast on the last entry, m_tuser holds the
// flag for a non-positive pivot.
// Configuration channel cfg_*: writes matrix_size (1..8); the user must
// write it only while idle, which the block does not enforce. Loading
// accepts one element per cycle. Each lower entry (i,j) goes through the
// store read, the dot product and saturation, then the square root, two
// bits a cycle, on the diagonal or the bit-serial divider below it, which
// gives zero without iterating when the pivot or divisor is not positive.
// These units set the latency. Entries then leave one at a time.
// During factorization and output s_tready is low.
// Reset returns to loading with matrix_size 8 and the error flag clear.
// A stalled receiver holds the output register and pauses the emission.
module cholesky_decomposition_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // element
	input  logic        s_tlast,   // last_element
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // factor_value, row, column, zero fill
	output logic        m_tuser,   // not_positive
	output logic        m_tlast,   // last_entry
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data   // matrix_size
);
	import chol_pkg::*;

	chol_cmd_t  cmd;
	chol_stat_t stat;
	logic [5:0] load_addr, rd_addr;
	logic out_last;
	logic [39:0] dp_data;
	logic [3:0] cfg_clip;

	assign cfg_clip = (cfg_data > 4'(MAX_SIZE)) ? 4'(MAX_SIZE) : cfg_data;

	chol_ctrl u_ctrl (
		.clk, .arst_n, .s_valid(s_tvalid), .s_ready(s_tready), .s_last(s_tlast),
		.cfg_valid, .cfg_ready, .cfg_data(cfg_clip), .stat, .cmd,
		.load_addr, .rd_addr, .out_last
	);

	chol_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .in_element(s_tdata), .load_addr, .rd_addr,
		.out_last, .m_valid(m_tvalid), .m_ready(m_tready), .m_data(dp_data),
		.m_last(m_tlast)
	);

	assign m_tdata = {2'b00, dp_data[37:0]};
	assign m_tuser = dp_data[38];

endmodule

@@ bench/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXN = 8;
	localparam int DEPTH = 64;
	localparam int IDLE_LIMIT = 40000;

	typedef struct {
		logic signed [31:0] value;
		logic [2:0]         row;
		logic [2:0]         column;
		logic               not_positive;
		logic               last_entry;
	} factor_entry_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = '0;

	// Model state of the block.
	logic [31:0]   shadow_store [DEPTH];
	int unsigned   shadow_count;
	logic [3:0]    shadow_size;
	factor_entry_t pending_entries [$];

	// Stimulus bookkeeping.
	logic signed [31:0] mat [MAXN][MAXN];
	int unsigned items_sent;
	int unsigned burst_left;
	int unsigned error_count;
	int unsigned idle_cycles;

	always #2 clk = ~clk;

	cholesky_decomposition_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Integer square root, floor, one result bit per step.
	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint clamp_q(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Factor the stored matrix and queue every emitted entry.
	task automatic factor_matrix();
		longint lf [MAXN][MAXN];
		longint s;
		longint p;
		int n;
		logic err;
		factor_entry_t e;
		n = shadow_size;
		if (n < 1) n = 1;
		if (n > MAXN) n = MAXN;
		err = 1'b0;
		for (int i = 0; i < MAXN; i++)
			for (int j = 0; j < MAXN; j++) lf[i][j] = 0;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j <= i; j++) begin
				s = longint'($signed(shadow_store[(i * n + j) % DEPTH]));
				for (int k = 0; k < j; k++) begin
					p = lf[i][k] * lf[j][k];
					s = s - ((p + (64'sd1 <<< 29)) >>> 30);
				end
				s = clamp_q(s);
				if (i == j) begin
					if (s <= 0) begin
						err = 1'b1;
						lf[i][j] = 0;
					end else begin
						lf[i][j] = longint'(root_floor(64'(s) << 30));
					end
				end else if (lf[j][j] <= 0) begin
					lf[i][j] = 0;
				end else begin
					lf[i][j] = clamp_q((s * (64'sd1 <<< 30)) / lf[j][j]);
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				e.value = (j <= i) ? lf[i][j][31:0] : 32'sd0;
				e.row = i[2:0];
				e.column = j[2:0];
				e.not_positive = err;
				e.last_entry = (i == n - 1) && (j == n - 1);
				pending_entries.push_back(e);
			end
		end
		shadow_count = 0;
	endtask

	// Send one element, with random gaps between bursts.
	task automatic send_element(input logic [31:0] data, input logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (shadow_count < DEPTH) begin
			shadow_store[shadow_count] = data;
			shadow_count++;
		end
		items_sent++;
		if (last) factor_matrix();
	endtask

	// Wait until the block is idle, then write matrix_size.
	task automatic write_size(input logic [3:0] size);
		s_tvalid <= 1'b0;
		wait (pending_entries.size() == 0);
		repeat (20) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= size;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_size = size;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int eff_size();
		if (shadow_size < 1) return 1;
		if (shadow_size > MAXN) return MAXN;
		return shadow_size;
	endfunction

	// Diagonally dominant symmetric matrix; upper half random since it is ignored.
	task automatic make_spd(input int n);
		int row_sum;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < i; j++) mat[i][j] = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
		end
		for (int i = 0; i < n; i++) begin
			row_sum = 0;
			for (int j = 0; j < n; j++) begin
				if (j < i) row_sum += (mat[i][j] < 0) ? -mat[i][j] : mat[i][j];
				if (j > i) row_sum += (mat[j][i] < 0) ? -mat[j][i] : mat[j][i];
			end
			mat[i][i] = row_sum + $urandom_range(1, 1 << 28);
			for (int j = i + 1; j < n; j++) mat[i][j] = $urandom;
		end
	endtask

	task automatic make_noise(input int n);
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) mat[i][j] = $urandom;
	endtask

	// Send count elements of mat in row-major order, the last one marked.
	task automatic send_matrix(input int n, input int count);
		for (int t = 0; t < count; t++)
			send_element(mat[(t / n) % n][t % n], t == count - 1);
	endtask

	task automatic test_full_load_with_overflow();
		make_spd(MAXN);
		// Three extra elements past the store depth are dropped.
		for (int t = 0; t < DEPTH + 3; t++)
			send_element((t < DEPTH) ? mat[t / MAXN][t % MAXN] : $urandom, t == DEPTH + 2);
	endtask

	task automatic test_single_element_extremes();
		write_size(4'd1);
		send_element(32'h7fffffff, 1'b1);
		send_element(32'h80000000, 1'b1);
		send_element(32'h00000000, 1'b1);
		send_element(32'h40000000, 1'b1);
	endtask

	task automatic test_size_codes();
		// Zero acts as one, fifteen acts as the maximum.
		write_size(4'd0);
		send_element(32'h00000001, 1'b1);
		write_size(4'd15);
		make_spd(MAXN);
		send_matrix(MAXN, MAXN * MAXN);
	endtask

	task automatic test_nonpositive_pivot();
		write_size(4'd3);
		make_spd(3);
		mat[1][1] = -mat[1][1];
		send_matrix(3, 9);
	endtask

	task automatic test_random();
		int n;
		int pick;
		int count;
		while (items_sent < 220) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) write_size(4'd8);
			else if (pick == 1) write_size(4'($urandom_range(0, 1) ? 0 : 15));
			else write_size(4'($urandom_range(1, 4)));
			n = eff_size();
			pick = $urandom_range(0, 9);
			count = n * n;
			if (pick == 0) make_noise(n);
			else make_spd(n);
			// Broken frames: short or too long.
			if (pick == 1) count = $urandom_range(1, n * n);
			if (pick == 2) count = n * n + $urandom_range(1, 4);
			send_matrix(n, count);
		end
	endtask

	// Compare each output transaction with the oldest expected entry.
	always @(posedge clk) begin
		factor_entry_t e;
		if (m_tvalid && m_tready) begin
			if (pending_entries.size() == 0) begin
				$error("unexpected output transaction data=%h", m_tdata);
				error_count++;
			end else begin
				e = pending_entries.pop_front();
				if (m_tdata[31:0] !== e.value) begin
					$error("factor_value expected %h actual %h", e.value, m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[34:32] !== e.row) begin
					$error("row expected %0d actual %0d", e.row, m_tdata[34:32]);
					error_count++;
				end
				if (m_tdata[37:35] !== e.column) begin
					$error("column expected %0d actual %0d", e.column, m_tdata[37:35]);
					error_count++;
				end
				if (m_tuser !== e.not_positive) begin
					$error("not_positive expected %b actual %b", e.not_positive, m_tuser);
					error_count++;
				end
				if (m_tlast !== e.last_entry) begin
					$error("last_entry expected %b actual %b", e.last_entry, m_tlast);
					error_count++;
				end
			end
		end
	end

	// Receiver stalls with a stall rate that changes at random intervals.
	always @(posedge clk) begin
		int unsigned phase_left;
		int unsigned stall_pct;
		if (phase_left == 0) begin
			phase_left = $urandom_range(50, 400);
			stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
		end
		phase_left--;
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		shadow_count = 0;
		shadow_size = 4'd8;
		items_sent = 0;
		burst_left = 0;
		error_count = 0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_load_with_overflow();
		test_single_element_extremes();
		test_size_codes();
		test_nonpositive_pivot();
		test_random();
		s_tvalid <= 1'b0;
		wait (pending_entries.size() == 0);
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
